/* design/utf16le_byte_stream_decoder_macros.svh */
// ----------------------------------------------------------------------------
// utf16le_byte_stream_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF16LE_BYTE_STREAM_DECODER_MACROS_SVH
`define UTF16LE_BYTE_STREAM_DECODER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define U16BSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, also checked while reset is held.
`define U16BSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/u16bsd_pkg.sv */
// ----------------------------------------------------------------------------
// u16bsd_pkg
// Types and constants shared by the UTF-16LE decoder modules.
// ----------------------------------------------------------------------------
package u16bsd_pkg;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

  // Upper six bits of a 16-bit unit that mark the surrogate halves
  localparam logic [5:0] TAG_HIGH_SURR = 6'b110110;
  localparam logic [5:0] TAG_LOW_SURR  = 6'b110111;

  localparam logic [2:0] USED_ONE  = 3'd1;
  localparam logic [2:0] USED_TWO  = 3'd2;
  localparam logic [2:0] USED_FOUR = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,  // nothing held
    PH_LOW       = 2'd1,  // low byte of a unit held
    PH_HIGH      = 2'd2,  // high surrogate held
    PH_HIGH_LOW  = 2'd3   // high surrogate plus next low byte held
  } phase_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  bytes_used;
  } result_t;

  // One queue entry: the results caused by one input byte
  typedef struct packed {
    result_t first;
    result_t second;
    logic    has_second;
    logic    final_byte;
  } entry_t;

endpackage

/* design/utf16le_byte_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf16le_byte_stream_decoder
// Path: a byte's results go into a queue slot, then into the output register.
// Throughput: one byte per cycle while the queue is not full; one code point
// per cycle on out_* unless stalled; two code points of one byte go out in turn.
// The queue between front and back (QUEUE_DEPTH entries) absorbs stalls.
// Reset: synchronous rst_n low empties the queue and drops any held bytes.
// ----------------------------------------------------------------------------
module utf16le_byte_stream_decoder
  import u16bsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] bytes_used
  output logic        out_tuser,  // run_end
  output logic        out_tlast   // buffer_end
);

  logic   q_full, q_push, q_pop, q_not_empty;
  entry_t q_in, q_head;

  u16bsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  u16bsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head_entry (q_head)
  );

  u16bsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

/* design/u16bsd_front.sv */
// ----------------------------------------------------------------------------
// u16bsd_front
// Accepts bytes, pairs them into units and classifies surrogates; for a byte
// that completes a result, pushes its one or two results into the queue.
// ----------------------------------------------------------------------------
module u16bsd_front
  import u16bsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // final_byte
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_low_r, held_low_nxt;
  logic [9:0]  held_hs_r, held_hs_nxt;
  logic [15:0] unit;
  logic        accept;
  logic        emit;
  logic        is_high, is_low;
  result_t     res_repl1, res_repl2, res_plain, res_supp;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign unit      = {in_tdata, held_low_r};
  assign is_high   = (unit[15:10] == TAG_HIGH_SURR);
  assign is_low    = (unit[15:10] == TAG_LOW_SURR);

  assign res_repl1 = '{code_point: CP_REPLACEMENT, bytes_used: USED_ONE};
  assign res_repl2 = '{code_point: CP_REPLACEMENT, bytes_used: USED_TWO};
  // A non-high unit decoded on its own: lone low surrogate is malformed
  assign res_plain = is_low ? res_repl2
                            : result_t'{code_point: {5'd0, unit}, bytes_used: USED_TWO};
  assign res_supp  = '{code_point: CP_SUPP_BASE + {1'b0, held_hs_r, unit[9:0]},
                       bytes_used: USED_FOUR};

  always_comb begin
    phase_nxt    = phase_r;
    held_low_nxt = held_low_r;
    held_hs_nxt  = held_hs_r;
    emit                = 1'b0;
    q_entry.first       = res_repl2;
    q_entry.second      = res_repl2;
    q_entry.has_second  = 1'b0;
    q_entry.final_byte  = in_tlast;
    case (phase_r)
      PH_IDLE: begin
        if (in_tlast) begin
          emit          = 1'b1;
          q_entry.first = res_repl1;
        end else begin
          held_low_nxt = in_tdata;
          phase_nxt    = PH_LOW;
        end
      end
      PH_LOW: begin
        phase_nxt = PH_IDLE;
        if (is_high) begin
          if (in_tlast) begin
            emit = 1'b1;
          end else begin
            held_hs_nxt = unit[9:0];
            phase_nxt   = PH_HIGH;
          end
        end else begin
          emit          = 1'b1;
          q_entry.first = res_plain;
        end
      end
      PH_HIGH: begin
        if (in_tlast) begin
          emit               = 1'b1;
          q_entry.second     = res_repl1;
          q_entry.has_second = 1'b1;
          phase_nxt          = PH_IDLE;
        end else begin
          held_low_nxt = in_tdata;
          phase_nxt    = PH_HIGH_LOW;
        end
      end
      PH_HIGH_LOW: begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
        if (is_low) begin
          q_entry.first = res_supp;
        end else if (is_high) begin
          // unpaired surrogate, then the new high one starts over
          if (in_tlast) begin
            q_entry.has_second = 1'b1;
          end else begin
            held_hs_nxt = unit[9:0];
            phase_nxt   = PH_HIGH;
          end
        end else begin
          q_entry.second     = res_plain;
          q_entry.has_second = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (in_tlast) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_low_r <= held_low_nxt;
      held_hs_r  <= held_hs_nxt;
    end
  end

endmodule

/* design/u16bsd_fifo.sv */
// ----------------------------------------------------------------------------
// u16bsd_fifo
// Short queue of per-byte result entries between front and back.
// ----------------------------------------------------------------------------
`include "utf16le_byte_stream_decoder_macros.svh"

module u16bsd_fifo
  import u16bsd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign not_empty  = (count_r != '0);
  assign head_entry = slots[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

  `U16BSD_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
  `U16BSD_ASSERT(a_no_pop_empty, pop |-> not_empty, "pop from empty queue")
  `U16BSD_ASSERT(a_count_bound, count_r <= FULL_CNT, "queue count out of range")

endmodule

/* design/u16bsd_back.sv */
// ----------------------------------------------------------------------------
// u16bsd_back
// Drains queue entries onto the result stream, one code point per
// transaction, splitting two-result entries into two transactions.
// ----------------------------------------------------------------------------
`include "utf16le_byte_stream_decoder_macros.svh"

module u16bsd_back
  import u16bsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  entry_t      q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] bytes_used
  output logic        out_tuser,  // run_end
  output logic        out_tlast   // buffer_end
);

  logic    out_valid_r;
  result_t out_res_r;
  logic    out_run_end_r;
  logic    out_last_r;
  logic    pend_r;
  result_t pend_res_r;
  logic    pend_last_r;
  logic    out_free;

  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = out_free && !pend_r && q_not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= q_not_empty;
        pend_r      <= q_not_empty && q_head.has_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_r) begin
        out_res_r     <= pend_res_r;
        out_run_end_r <= 1'b1;
        out_last_r    <= pend_last_r;
      end else if (q_not_empty) begin
        out_res_r     <= q_head.first;
        out_run_end_r <= !q_head.has_second;
        out_last_r    <= !q_head.has_second && q_head.final_byte;
        pend_res_r    <= q_head.second;
        pend_last_r   <= q_head.final_byte;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.bytes_used, out_res_r.code_point};
  assign out_tuser  = out_run_end_r;
  assign out_tlast  = out_last_r;

  `U16BSD_ASSERT(a_pend_busy, pend_r |-> out_valid_r, "second result pending with idle output")
  `U16BSD_ASSERT(a_pend_first, pend_r |-> (!out_run_end_r && !out_last_r), "first of pair marked as run end")
  `U16BSD_ASSERT(a_pop_no_pend, q_pop |-> !pend_r, "entry popped while second result pending")

endmodule
